// ===== hw/rtl/gec_pkg.sv =====
// shared types and constants for the group energy channel appender
package gec_pkg;

  localparam int NGROUPS   = 4;
  localparam int NCFG      = 2 * NGROUPS;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = $clog2(NCFG);
  localparam int VAL_W     = 16;
  localparam int GRP_W     = $clog2(NGROUPS);
  localparam int SUM_W     = 24;
  localparam int SQ_W      = 39;
  localparam int SQR_W     = 2 * VAL_W;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int ROOT_W    = PROD_W / 2;
  localparam int SREM_W    = ROOT_W + 1;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W    = $clog2(ROOT_STEPS);

  localparam logic [GRP_W-1:0] LAST_GROUP = GRP_W'(NGROUPS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROUP0_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP0_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP1_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP1_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP2_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP2_END   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP3_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP3_END   = 3'd7;

  localparam logic [CFG_W-1:0] CFG_RESET [NCFG] = '{
    9'd0, 9'd64, 9'd64, 9'd128, 9'd128, 9'd192, 9'd192, 9'd256
  };

  typedef struct packed {
    logic             accept;
    logic             mul;
    logic             sub;
    logic             sqrt_step;
    logic             div_step;
    logic             push;
    logic             clear;
    logic [GRP_W-1:0] grp;
  } gec_cmd_t;

  typedef struct packed {
    logic row_end;
  } gec_status_t;

endpackage

// ===== hw/rtl/gec_in_if.sv =====
// input channel: feature beats with row-end flag
interface gec_in_if;
  import gec_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] feature_value;
  logic             last_in_row;

  modport source (output valid, output feature_value, output last_in_row, input ready);
  modport sink   (input valid, input feature_value, input last_in_row, output ready);
endinterface

// ===== hw/rtl/gec_out_if.sv =====
// result channel: copied features and appended group values
interface gec_out_if;
  import gec_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] out_value;
  logic             is_group_channel;
  logic [GRP_W-1:0] group_index;
  logic             last;

  modport source (output valid, output out_value, output is_group_channel,
                  output group_index, output last, input ready);
  modport sink   (input valid, input out_value, input is_group_channel,
                  input group_index, input last, output ready);
endinterface

// ===== hw/rtl/group_energy_channel_appender.sv =====
// top level: appends per-group standard deviations to a stream of feature rows
//
// in_ch carries one Q1.15 feature per beat, last_in_row closing a row. Every
// feature comes back on out_ch unchanged in the cycle after it is taken, so
// rows stream at one beat per cycle while the receiver keeps up. The output
// register is reloaded in the same cycle that it drains.
// After the beat that closes a row, in_ch.ready drops while the four group
// values are worked out one after the other in a shared unit: a multiply,
// a subtract, 24 square-root steps and 24 divide steps, then the push into
// the output register. Group 3 carries out_ch.last.
// Group ranges are to be written through cfg_we/cfg_idx/cfg_data while idle;
// the block itself does not enforce this.
// A stalled receiver holds the output register and in_ch.ready stays low
// until it drains. Reset (rst_n low, synchronous) restores the default
// ranges and clears the row position and all group sums.
module group_energy_channel_appender
  import gec_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gec_in_if.sink               in_ch,
  gec_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  gec_cmd_t    cmd;
  gec_status_t status;

  gec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  gec_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .feature_value    (in_ch.feature_value),
    .last_in_row      (in_ch.last_in_row),
    .cmd              (cmd),
    .status           (status),
    .out_value        (out_ch.out_value),
    .is_group_channel (out_ch.is_group_channel),
    .group_index      (out_ch.group_index),
    .last             (out_ch.last)
  );

  // never take a beat that would overwrite an undelivered result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input taken while output register is blocked");

  // a row end stops input while group values are computed
  a_row_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_in_row) |=> !in_ch.ready)
    else $error("input accepted right after row end");

  a_last_is_group3: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |->
      (out_ch.is_group_channel && out_ch.group_index == LAST_GROUP))
    else $error("last flag on a beat other than group 3");

  a_copy_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_group_channel) |->
      (out_ch.group_index == '0 && !out_ch.last))
    else $error("copied feature with group fields set");

endmodule

// ===== hw/rtl/gec_ctrl.sv =====
// controller: input acceptance, row-end sequencing, output register valid
module gec_ctrl
  import gec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        out_ready,
  output logic        out_valid,
  input  gec_status_t status,
  output gec_cmd_t    cmd
);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  // output register can take a beat when empty or draining now
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IN) && slot_free;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.grp   = grp_r;
    unique case (state_r)
      S_IN: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (status.row_end) begin
            grp_nxt   = '0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_PUSH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          cmd.push = 1'b1;
          if (grp_r == LAST_GROUP) begin
            cmd.clear = 1'b1;
            state_nxt = S_IN;
          end else begin
            grp_nxt   = grp_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IN;
    endcase
  end

  always_comb begin
    if (cmd.accept || cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      grp_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/gec_dp.sv =====
// datapath: config registers, group accumulators, root and divide unit, output register
module gec_dp
  import gec_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [VAL_W-1:0]     feature_value,
  input  logic                 last_in_row,
  input  gec_cmd_t             cmd,
  output gec_status_t          status,
  output logic [VAL_W-1:0]     out_value,
  output logic                 is_group_channel,
  output logic [GRP_W-1:0]     group_index,
  output logic                 last
);

  localparam int PW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  logic [CFG_W-1:0]  cfg_r [NCFG];
  logic [PW-1:0]     pos_r;
  logic [SUM_W-1:0]  sum_r [NGROUPS];
  logic [SQ_W-1:0]   sq_r  [NGROUPS];

  logic [PROD_W-1:0] nq_r, ss_r, rad_r;
  logic [CFG_W-1:0]  n_r;
  logic              empty_r;
  logic [ROOT_W-1:0] root_r;
  logic [SREM_W-1:0] srem_r;
  logic [CFG_W-1:0]  drem_r;

  logic [VAL_W-1:0]  out_value_r;
  logic              is_group_r;
  logic [GRP_W-1:0]  group_index_r;
  logic              last_r;

  logic [SQR_W-1:0]  x_sq;
  logic              pos_live;
  logic [CW-1:0]     pos_ext;
  logic [CFG_W-1:0]  sel_start, sel_end;
  logic [SREM_W+1:0] srem_sh, strial;
  logic [CFG_W:0]    dsh;
  logic [VAL_W-1:0]  grp_value;

  assign status.row_end = last_in_row;

  assign x_sq     = SQR_W'(feature_value) * SQR_W'(feature_value);
  assign pos_live = (pos_r < PW'(MAX_ROW_LENGTH));
  assign pos_ext  = CW'(pos_r);

  assign sel_start = cfg_r[{cmd.grp, 1'b0}];
  assign sel_end   = cfg_r[{cmd.grp, 1'b1}];

  assign srem_sh = {srem_r, rad_r[PROD_W-1 -: 2]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign dsh     = {drem_r, root_r[ROOT_W-1]};

  // quotient saturates to the output width, empty group gives zero
  assign grp_value = empty_r ? '0 :
                     (|root_r[ROOT_W-1:VAL_W]) ? {VAL_W{1'b1}} : root_r[VAL_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCFG; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_data;
    end
  end

  // row position and group accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      pos_r <= '0;
      for (int g = 0; g < NGROUPS; g++) begin
        sum_r[g] <= '0;
        sq_r[g]  <= '0;
      end
    end else if (cmd.accept && pos_live) begin
      pos_r <= pos_r + 1'b1;
      for (int g = 0; g < NGROUPS; g++) begin
        if (pos_ext >= CW'(cfg_r[2*g]) && pos_ext < CW'(cfg_r[2*g+1])) begin
          logic [SUM_W:0] s_ext;
          logic [SQ_W:0]  q_ext;
          s_ext = {1'b0, sum_r[g]} + (SUM_W + 1)'(feature_value);
          q_ext = {1'b0, sq_r[g]} + (SQ_W + 1)'(x_sq);
          sum_r[g] <= s_ext[SUM_W] ? {SUM_W{1'b1}} : s_ext[SUM_W-1:0];
          sq_r[g]  <= q_ext[SQ_W]  ? {SQ_W{1'b1}}  : q_ext[SQ_W-1:0];
        end
      end
    end
  end

  // row-end arithmetic: n*Q - S*S, bit-pair square root, restoring divide by n
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      n_r     <= sel_end - sel_start;
      empty_r <= (sel_end <= sel_start);
      nq_r    <= PROD_W'(sel_end - sel_start) * PROD_W'(sq_r[cmd.grp]);
      ss_r    <= PROD_W'(sum_r[cmd.grp]) * PROD_W'(sum_r[cmd.grp]);
    end
    if (cmd.sub) begin
      rad_r  <= (!empty_r && nq_r > ss_r) ? nq_r - ss_r : '0;
      root_r <= '0;
      srem_r <= '0;
      drem_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[PROD_W-3:0], 2'b00};
      if (srem_sh >= strial) begin
        srem_r <= SREM_W'(srem_sh - strial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= srem_sh[SREM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    // dividend shifts out the top while quotient bits enter at the bottom
    if (cmd.div_step) begin
      if (dsh >= {1'b0, n_r}) begin
        drem_r <= CFG_W'(dsh - {1'b0, n_r});
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        drem_r <= dsh[CFG_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_value_r   <= feature_value;
      is_group_r    <= 1'b0;
      group_index_r <= '0;
      last_r        <= 1'b0;
    end else if (cmd.push) begin
      out_value_r   <= grp_value;
      is_group_r    <= 1'b1;
      group_index_r <= cmd.grp;
      last_r        <= (cmd.grp == LAST_GROUP);
    end
  end

  assign out_value        = out_value_r;
  assign is_group_channel = is_group_r;
  assign group_index      = group_index_r;
  assign last             = last_r;

endmodule

// ===== dv/gec_stream_checker.sv =====
// stream checker: predicts copied features and group deviations, compares result beats
module gec_stream_checker
  import gec_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gec_in_if                    in_ch,
  gec_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   pending_results
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_group;
    logic [GRP_W-1:0] group;
    logic             last;
  } result_beat_t;

  // even index holds a group start, odd index the end just past it
  logic [CFG_W-1:0] range_reg [NCFG];
  int               row_pos;
  logic [SUM_W-1:0] sum_acc [NGROUPS];
  logic [SQ_W-1:0]  sq_acc [NGROUPS];
  result_beat_t     owed_beats [$];
  result_beat_t     want;
  result_beat_t     got;
  int               errors;

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] trial;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= x) res = trial;
    end
    return res;
  endfunction

  // floor(sqrt(n*Q - S*S) / n), zero for an empty range or a non-positive variance
  function automatic logic [VAL_W-1:0] group_deviation(input int g);
    logic [63:0] n;
    logic [63:0] nq;
    logic [63:0] ss;
    logic [63:0] r;
    if (range_reg[2*g+1] <= range_reg[2*g]) return '0;
    n  = 64'(range_reg[2*g+1]) - 64'(range_reg[2*g]);
    nq = n * 64'(sq_acc[g]);
    ss = 64'(sum_acc[g]) * 64'(sum_acc[g]);
    if (nq <= ss) return '0;
    r = root_floor(nq - ss) / n;
    return (r > 64'hFFFF) ? 16'hFFFF : r[VAL_W-1:0];
  endfunction

  function automatic void clear_row();
    row_pos = 0;
    for (int g = 0; g < NGROUPS; g++) begin
      sum_acc[g] = '0;
      sq_acc[g]  = '0;
    end
  endfunction

  function automatic void take_feature(input logic [VAL_W-1:0] x, input logic closes_row);
    logic [SUM_W:0] s_next;
    logic [SQ_W:0]  q_next;
    if (row_pos < MAX_ROW_LENGTH) begin
      for (int g = 0; g < NGROUPS; g++) begin
        if (row_pos >= range_reg[2*g] && row_pos < range_reg[2*g+1]) begin
          s_next     = {1'b0, sum_acc[g]} + (SUM_W+1)'(x);
          q_next     = {1'b0, sq_acc[g]} + (SQ_W+1)'(x) * (SQ_W+1)'(x);
          sum_acc[g] = s_next[SUM_W] ? '1 : s_next[SUM_W-1:0];
          sq_acc[g]  = q_next[SQ_W] ? '1 : q_next[SQ_W-1:0];
        end
      end
      row_pos++;
    end
    owed_beats.push_back('{x, 1'b0, '0, 1'b0});
    if (closes_row) begin
      for (int g = 0; g < NGROUPS; g++) begin
        owed_beats.push_back('{group_deviation(g), 1'b1, GRP_W'(g), (g == NGROUPS - 1)});
      end
      clear_row();
    end
  endfunction

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, expected, actual);
      end
    end
  endtask

  initial begin
    errors = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCFG; i++) range_reg[i] = CFG_RESET[i];
      clear_row();
      owed_beats.delete();
    end else begin
      if (cfg_we) range_reg[cfg_idx] = cfg_data;
      if (in_ch.valid && in_ch.ready) take_feature(in_ch.feature_value, in_ch.last_in_row);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_value, out_ch.is_group_channel, out_ch.group_index, out_ch.last};
        if (owed_beats.size() == 0) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t unexpected beat: expected none, got value %0h group %0b/%0d last %0b",
                     $time, got.value, got.is_group, got.group, got.last);
          end
        end else begin
          want = owed_beats.pop_front();
          check_field("out_value", want.value, got.value);
          check_field("is_group_channel", want.is_group, got.is_group);
          check_field("group_index", want.group, got.group);
          check_field("last", want.last, got.last);
        end
      end
    end
    pending_results <= owed_beats.size();
    mismatch_count  <= errors;
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: feature row stimulus, range programming and the verdict
module tb_top;
  import gec_pkg::*;

  localparam int ROW_LIMIT    = 256;
  localparam int RANDOM_ITEMS = 60;
  localparam int CALM_AFTER   = 40;

  localparam logic [CFG_IDX_W-1:0] START_REG [NGROUPS] = '{
    REG_GROUP0_START, REG_GROUP1_START, REG_GROUP2_START, REG_GROUP3_START
  };
  localparam logic [CFG_IDX_W-1:0] END_REG [NGROUPS] = '{
    REG_GROUP0_END, REG_GROUP1_END, REG_GROUP2_END, REG_GROUP3_END
  };

  typedef enum int {FILL_RANDOM, FILL_Q115, FILL_CONST, FILL_RAILS, FILL_SMALL} fill_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatch_count;
  int                   pending_results;
  bit                   src_idle;
  bit                   snk_idle;
  int                   range_lo [NGROUPS];
  int                   range_hi [NGROUPS];

  gec_in_if  in_ch();
  gec_out_if out_ch();

  group_energy_channel_appender #(.MAX_ROW_LENGTH(ROW_LIMIT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  gec_stream_checker #(.MAX_ROW_LENGTH(ROW_LIMIT)) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver stalls in random bursts while snk_idle is set
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (snk_idle && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic push_feature(input logic [VAL_W-1:0] v, input logic closes_row);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.feature_value <= v;
    in_ch.last_in_row   <= closes_row;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_row(input int len, input fill_t shape, input logic [VAL_W-1:0] level);
    logic [VAL_W-1:0] v;
    for (int k = 0; k < len; k++) begin
      case (shape)
        FILL_RANDOM: v = VAL_W'($urandom);
        FILL_Q115:   v = VAL_W'($urandom_range(0, 32768));
        FILL_CONST:  v = level;
        FILL_RAILS:  v = $urandom_range(0, 1) ? '1 : '0;
        default:     v = VAL_W'($urandom_range(0, 255));
      endcase
      push_feature(v, k == len - 1);
    end
  endtask

  // stop sending and wait for every owed beat to come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic program_ranges();
    for (int g = 0; g < NGROUPS; g++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= START_REG[g];
      cfg_data <= CFG_W'(range_lo[g]);
      @(posedge clk);
      cfg_idx  <= END_REG[g];
      cfg_data <= CFG_W'(range_hi[g]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic roll_ranges();
    for (int g = 0; g < NGROUPS; g++) begin
      case ($urandom_range(0, 5))
        0: begin
          range_lo[g] = 0;
          range_hi[g] = 256;
        end
        1: begin
          range_lo[g] = $urandom_range(0, 256);
          range_hi[g] = $urandom_range(0, range_lo[g]);
        end
        2: begin
          range_lo[g] = $urandom_range(0, 255);
          range_hi[g] = range_lo[g] + 1;
        end
        3: begin
          range_lo[g] = $urandom_range(0, 256);
          range_hi[g] = $urandom_range(0, 256);
        end
        default: begin
          range_lo[g] = $urandom_range(0, 40);
          range_hi[g] = range_lo[g] + $urandom_range(1, 48);
        end
      endcase
    end
  endtask

  initial begin
    int    items_sent;
    int    len;
    fill_t shape;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_GROUP0_START;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.feature_value <= '0;
    in_ch.last_in_row   <= 1'b0;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default ranges: single-beat row, then field extremes
    push_feature(16'h0000, 1'b1);
    push_feature(16'hFFFF, 1'b0);
    push_feature(16'h8000, 1'b0);
    push_feature(16'h0001, 1'b0);
    push_feature(16'h5555, 1'b0);
    push_feature(16'hAAAA, 1'b1);
    drain();

    // overlapping groups, an equal-bounds group and a reversed group
    range_lo = '{0, 2, 5, 7};
    range_hi = '{4, 6, 5, 3};
    program_ranges();
    push_feature(16'hFFFF, 1'b0);
    push_feature(16'h0000, 1'b0);
    push_feature(16'hFFFF, 1'b0);
    push_feature(16'h0000, 1'b0);
    push_feature(16'h8000, 1'b0);
    push_feature(16'h0001, 1'b1);
    push_feature(16'h3039, 1'b1);
    send_row(4, FILL_CONST, 16'd1000);
    drain();

    // full-width rails past the row limit: square sum saturates, variance floors to zero
    src_idle = 1'b1;
    snk_idle = 1'b1;
    range_lo = '{0, 128, 256, 255};
    range_hi = '{256, 256, 256, 256};
    program_ranges();
    send_row(ROW_LIMIT + 4, FILL_CONST, 16'hFFFF);
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      roll_ranges();
      program_ranges();
      src_idle = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      snk_idle = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 19)) inside
          0:       len = 1;
          [1:9]:   len = $urandom_range(2, 16);
          [10:15]: len = $urandom_range(17, 70);
          [16:18]: len = $urandom_range(71, 160);
          default: len = $urandom_range(161, ROW_LIMIT + 8);
        endcase
        shape = fill_t'($urandom_range(0, 4));
        send_row(len, shape, VAL_W'($urandom));
        items_sent += len;
      end
      drain();
    end

    // closing rows with no idling on either side
    src_idle = 1'b0;
    snk_idle = 1'b0;
    roll_ranges();
    program_ranges();
    send_row(16, FILL_Q115, '0);
    send_row(24, FILL_RANDOM, '0);
    drain();

    // room for a stray beat after the last expected one
    repeat (250) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gec_pkg.sv
hw/rtl/gec_in_if.sv
hw/rtl/gec_out_if.sv
hw/rtl/gec_ctrl.sv
hw/rtl/gec_dp.sv
hw/rtl/group_energy_channel_appender.sv
dv/gec_stream_checker.sv
dv/tb_top.sv
